// ----- rtl/pkcs1pc_pkg.sv -----
package pkcs1pc_pkg;

  // default sizes of the reference store
  localparam int DEF_MAX_OID_BYTES    = 32;
  localparam int DEF_MAX_DIGEST_BYTES = 64;

  // field widths fixed by the interface
  localparam int BYTE_W     = 8;
  localparam int OID_LEN_W  = 6;
  localparam int DIG_LEN_W  = 7;
  localparam int FIDX_W     = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  // store addresses stay below 256 for every legal depth and offset
  localparam int REF_ADDR_W = 8;

  // padding counter saturates at the minimum run, only that bound matters
  localparam int                 PAD_W   = 4;
  localparam logic [PAD_W-1:0]   MIN_PAD = 4'd8;

  // register reset values
  localparam logic [OID_LEN_W-1:0] OID_LEN_RST = 6'd9;
  localparam logic [DIG_LEN_W-1:0] DIG_LEN_RST = 7'd32;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_OID_LENGTH   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DIGEST_BYTES = 1'b1;

  // der and padding byte values
  localparam logic [BYTE_W-1:0] BYTE_ZERO     = 8'h00;
  localparam logic [BYTE_W-1:0] BYTE_BT01     = 8'h01;
  localparam logic [BYTE_W-1:0] BYTE_PAD      = 8'hff;
  localparam logic [BYTE_W-1:0] TAG_SEQUENCE  = 8'h30;
  localparam logic [BYTE_W-1:0] TAG_OID       = 8'h06;
  localparam logic [BYTE_W-1:0] TAG_NULL      = 8'h05;
  localparam logic [BYTE_W-1:0] TAG_OCTET_STR = 8'h04;
  localparam logic [BYTE_W-1:0] SEQ_LEN_BASE  = 8'h08;
  localparam logic [BYTE_W-1:0] ALG_LEN_BASE  = 8'h04;

  typedef enum logic [3:0] {
    PH_LEAD0,
    PH_LEAD1,
    PH_PAD,
    PH_SEQ_TAG,
    PH_SEQ_LEN,
    PH_ALG_TAG,
    PH_ALG_LEN,
    PH_OID_TAG,
    PH_OID_LEN,
    PH_OID_BYTES,
    PH_NULL_TAG,
    PH_NULL_LEN,
    PH_OCT_TAG,
    PH_OCT_LEN,
    PH_DIGEST,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic                  en;
    logic [REF_ADDR_W-1:0] addr;
    logic [BYTE_W-1:0]     data;
  } store_wr_t;

endpackage

// ----- rtl/pkcs1pc_ref_store.sv -----
module pkcs1pc_ref_store
  import pkcs1pc_pkg::*;
#(
  parameter int DEPTH = DEF_MAX_OID_BYTES + DEF_MAX_DIGEST_BYTES
) (
  input  logic                  clk,
  input  store_wr_t             wr,
  input  logic [REF_ADDR_W-1:0] rd_addr,
  output logic [BYTE_W-1:0]     rd_data
);

  localparam int IDX_W = $clog2(DEPTH);

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr[IDX_W-1:0]] <= wr.data;
    end
  end

  // beyond the store reads zero; same-cycle write is forwarded
  always_ff @(posedge clk) begin
    if (rd_addr >= REF_ADDR_W'(DEPTH)) begin
      rd_data_r <= BYTE_ZERO;
    end else if (wr.en && (wr.addr == rd_addr)) begin
      rd_data_r <= wr.data;
    end else begin
      rd_data_r <= mem[rd_addr[IDX_W-1:0]];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/pkcs1_padding_checker_unit.sv -----
// a final message byte's verdict is registered and shows on out_valid in the cycle after it is accepted
// throughput: one item per cycle, reference loads and message bytes alike
// a final byte waits only while an earlier verdict sits stalled in the result register
// the store read is issued from the next-state phase and index, so no byte waits on memory
// reset (rst_n low, synchronous) restores the check state, both size registers and out_valid;
// the reference store is not cleared and holds garbage until loaded
module pkcs1_padding_checker_unit
  import pkcs1pc_pkg::*;
#(
  parameter int MAX_OID_BYTES    = DEF_MAX_OID_BYTES,
  parameter int MAX_DIGEST_BYTES = DEF_MAX_DIGEST_BYTES
) (
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_action,
  input  logic [BYTE_W-1:0]     in_data_byte,
  input  logic                  in_last,

  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_valid_res,

  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int DEPTH = MAX_OID_BYTES + MAX_DIGEST_BYTES;
  localparam int PTR_W = $clog2(DEPTH + 1);

  // check state
  phase_t               phase_r, phase_nxt, chk_phase;
  logic [PAD_W-1:0]     pad_r, pad_nxt, chk_pad;
  logic [FIDX_W-1:0]    fidx_r, fidx_nxt, chk_fidx;
  logic                 failed_r, failed_nxt, chk_failed;
  logic [PTR_W-1:0]     ptr_r, ptr_nxt;

  // size registers
  logic [OID_LEN_W-1:0] oid_len_r, oid_len_nxt;
  logic [DIG_LEN_W-1:0] dig_len_r, dig_len_nxt;

  // result register
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_res_r, out_res_nxt;

  logic                 in_fire;
  logic                 msg_fire;
  logic                 load_fire;
  logic                 verdict;
  logic [BYTE_W-1:0]    ref_byte;
  logic [BYTE_W-1:0]    want_seq_len;
  logic [BYTE_W-1:0]    want_alg_len;
  logic [FIDX_W:0]      fidx_inc;
  logic [REF_ADDR_W-1:0] rd_addr;
  store_wr_t            store_wr;

  // handshakes
  // a final byte needs the result register free (or emptying this cycle)
  assign in_stall  = out_valid_r && out_stall && in_action && in_last;
  assign in_fire   = in_valid && !in_stall;
  assign msg_fire  = in_fire && in_action;
  assign load_fire = in_fire && !in_action;
  assign cfg_ready = 1'b1;

  // expected der lengths, all mod 256
  assign want_seq_len = SEQ_LEN_BASE + BYTE_W'(oid_len_r) + BYTE_W'(dig_len_r);
  assign want_alg_len = ALG_LEN_BASE + BYTE_W'(oid_len_r);
  assign fidx_inc     = {1'b0, fidx_r} + 1'b1;

  // one message byte against the current phase
  always_comb begin : step_logic
    chk_phase  = phase_r;
    chk_pad    = pad_r;
    chk_fidx   = fidx_r;
    chk_failed = failed_r;
    if (msg_fire && !failed_r) begin
      unique case (phase_r)
        PH_LEAD0: begin
          if (in_data_byte == BYTE_ZERO) chk_phase = PH_LEAD1;
          else chk_failed = 1'b1;
        end
        PH_LEAD1: begin
          if (in_data_byte == BYTE_BT01) chk_phase = PH_PAD;
          else chk_failed = 1'b1;
        end
        PH_PAD: begin
          if (in_data_byte == BYTE_PAD) begin
            if (pad_r < MIN_PAD) chk_pad = pad_r + 1'b1;
          end else if (in_data_byte == BYTE_ZERO && pad_r >= MIN_PAD) begin
            chk_phase = PH_SEQ_TAG;
          end else begin
            chk_failed = 1'b1;
          end
        end
        PH_SEQ_TAG: begin
          if (in_data_byte == TAG_SEQUENCE) chk_phase = PH_SEQ_LEN;
          else chk_failed = 1'b1;
        end
        PH_SEQ_LEN: begin
          if (in_data_byte == want_seq_len) chk_phase = PH_ALG_TAG;
          else chk_failed = 1'b1;
        end
        PH_ALG_TAG: begin
          if (in_data_byte == TAG_SEQUENCE) chk_phase = PH_ALG_LEN;
          else chk_failed = 1'b1;
        end
        PH_ALG_LEN: begin
          if (in_data_byte == want_alg_len) chk_phase = PH_OID_TAG;
          else chk_failed = 1'b1;
        end
        PH_OID_TAG: begin
          if (in_data_byte == TAG_OID) chk_phase = PH_OID_LEN;
          else chk_failed = 1'b1;
        end
        PH_OID_LEN: begin
          chk_fidx = '0;
          if (in_data_byte == BYTE_W'(oid_len_r)) begin
            // an empty oid skips straight to the null
            chk_phase = (oid_len_r == '0) ? PH_NULL_TAG : PH_OID_BYTES;
          end else begin
            chk_failed = 1'b1;
          end
        end
        PH_OID_BYTES: begin
          if (in_data_byte != ref_byte) begin
            chk_failed = 1'b1;
          end else if (fidx_inc >= (FIDX_W + 1)'(oid_len_r)) begin
            chk_fidx  = '0;
            chk_phase = PH_NULL_TAG;
          end else begin
            chk_fidx = fidx_inc[FIDX_W-1:0];
          end
        end
        PH_NULL_TAG: begin
          if (in_data_byte == TAG_NULL) chk_phase = PH_NULL_LEN;
          else chk_failed = 1'b1;
        end
        PH_NULL_LEN: begin
          if (in_data_byte == BYTE_ZERO) chk_phase = PH_OCT_TAG;
          else chk_failed = 1'b1;
        end
        PH_OCT_TAG: begin
          if (in_data_byte == TAG_OCTET_STR) chk_phase = PH_OCT_LEN;
          else chk_failed = 1'b1;
        end
        PH_OCT_LEN: begin
          chk_fidx = '0;
          if (in_data_byte == BYTE_W'(dig_len_r)) begin
            chk_phase = (dig_len_r == '0) ? PH_DONE : PH_DIGEST;
          end else begin
            chk_failed = 1'b1;
          end
        end
        PH_DIGEST: begin
          if (in_data_byte != ref_byte) begin
            chk_failed = 1'b1;
          end else if (fidx_inc >= (FIDX_W + 1)'(dig_len_r)) begin
            chk_fidx  = '0;
            chk_phase = PH_DONE;
          end else begin
            chk_fidx = fidx_inc[FIDX_W-1:0];
          end
        end
        PH_DONE: begin
          // trailing bytes are ignored
        end
      endcase
    end
  end

  // next state: a final byte ends the check and rearms the check state and the load pointer
  always_comb begin : next_state
    phase_nxt  = chk_phase;
    pad_nxt    = chk_pad;
    fidx_nxt   = chk_fidx;
    failed_nxt = chk_failed;
    ptr_nxt    = ptr_r;
    if (load_fire && ptr_r < PTR_W'(DEPTH)) begin
      ptr_nxt = ptr_r + 1'b1;
    end
    if (msg_fire && in_last) begin
      phase_nxt  = PH_LEAD0;
      pad_nxt    = '0;
      fidx_nxt   = '0;
      failed_nxt = 1'b0;
      ptr_nxt    = '0;
    end
  end

  // verdict and result register
  always_comb begin : out_logic
    verdict       = !chk_failed && (chk_phase == PH_DONE);
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (msg_fire && in_last) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = verdict;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // size registers
  always_comb begin : cfg_decode
    oid_len_nxt = oid_len_r;
    dig_len_nxt = dig_len_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_OID_LENGTH:   oid_len_nxt = cfg_data[OID_LEN_W-1:0];
        REG_DIGEST_BYTES: dig_len_nxt = cfg_data[DIG_LEN_W-1:0];
      endcase
    end
  end

  // read address for the byte after this edge, so the data is ready in time
  // oid bytes sit from entry 0, digest bytes follow at oid_length
  always_comb begin : rd_addr_logic
    if (phase_nxt == PH_DIGEST) begin
      rd_addr = REF_ADDR_W'(oid_len_nxt) + REF_ADDR_W'(fidx_nxt);
    end else begin
      rd_addr = REF_ADDR_W'(fidx_nxt);
    end
  end

  assign store_wr.en   = load_fire && (ptr_r < PTR_W'(DEPTH));
  assign store_wr.addr = REF_ADDR_W'(ptr_r);
  assign store_wr.data = in_data_byte;

  pkcs1pc_ref_store #(
    .DEPTH (DEPTH)
  ) u_ref_store (
    .clk     (clk),
    .wr      (store_wr),
    .rd_addr (rd_addr),
    .rd_data (ref_byte)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_LEAD0;
      pad_r       <= '0;
      fidx_r      <= '0;
      failed_r    <= 1'b0;
      ptr_r       <= '0;
      oid_len_r   <= OID_LEN_RST;
      dig_len_r   <= DIG_LEN_RST;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      pad_r       <= pad_nxt;
      fidx_r      <= fidx_nxt;
      failed_r    <= failed_nxt;
      ptr_r       <= ptr_nxt;
      oid_len_r   <= oid_len_nxt;
      dig_len_r   <= dig_len_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_valid_res = out_res_r;

`ifndef SYNTHESIS
  // a final message byte always rearms the check and posts a verdict
  a_last_rearms: assert property (@(posedge clk) disable iff (!rst_n)
    msg_fire && in_last |=> phase_r == PH_LEAD0 && !failed_r && ptr_r == '0 && out_valid_r)
    else $error("check not rearmed after final byte");

  // a verdict only appears for an accepted final message byte
  a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
    !(msg_fire && in_last) && !(out_valid_r && out_stall) |=> !out_valid_r)
    else $error("result without a final message byte");

  // a reference load below the store depth advances the load pointer by one
  a_load_advances: assert property (@(posedge clk) disable iff (!rst_n)
    load_fire && ptr_r < PTR_W'(DEPTH) |=> ptr_r == $past(ptr_r) + 1'b1)
    else $error("load pointer did not advance");

  // the padding run counter never passes its saturation point
  a_pad_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    pad_r <= MIN_PAD)
    else $error("padding counter past saturation");
`endif

endmodule
